// ----- hw/rtl/etg_pkg.sv -----
`default_nettype none
package etg_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_DUR   = 2'd2,
    REG_CURVE = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_QUAD   = 2'd1,
    CURVE_CUBIC  = 2'd2,
    CURVE_BACK   = 2'd3
  } curve_t;

  localparam logic [63:0] C1_Q30      = 64'd1827057613;
  localparam logic [63:0] DEF_DUR_Q30 = 64'd214748365;

  // Q30 constant rounded to nearest at the working fraction width.
  function automatic logic [63:0] q30_round(input logic [63:0] v, input int unsigned fb);
    logic [63:0] r;
    r = 64'd1 << (30 - fb - 1);
    return (v + r) >> (30 - fb);
  endfunction

  // Multiplier operation request.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

endpackage
`default_nettype wire

// ----- hw/rtl/etg_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module etg_div #(
  parameter int unsigned NUM_W = 48
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [31:0]      den,
  output logic                  busy,
  output logic [NUM_W-1:0]      quo
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r;
  logic [32:0]      rem_r;
  logic [31:0]      den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [33:0]      trial;

  assign trial = {rem_r, q_r[NUM_W-1]} - {2'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
      q_r    <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_r <= trial[32:0];
        q_r   <= {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[31:0], q_r[NUM_W-1]};
        q_r   <= {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;
endmodule
`default_nettype wire

// ----- hw/rtl/etg_mul.sv -----
`default_nettype none
// Signed fixed-point multiplier, rounded to nearest with ties away from zero.
// Magnitudes split into 32-bit halves; one partial product per cycle.
module etg_mul #(
  parameter int unsigned FRAC_BITS = etg_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  etg_pkg::mul_req_t req,
  output logic              busy,
  output logic [63:0]       prod
);
  import etg_pkg::*;

  logic [63:0]  ma_r, mb_r;
  logic         neg_r;
  logic [127:0] acc_r;
  logic [2:0]   ph_r;
  logic         busy_r;
  logic [63:0]  pp;
  logic [31:0]  opa, opb;
  logic [1:0]   hsel;       // number of upper halves in this partial product
  logic [127:0] sh;
  logic [127:0] rnd;
  logic [63:0]  mag;

  always_comb begin
    opa  = ph_r[1] ? ma_r[63:32] : ma_r[31:0];
    opb  = ph_r[0] ? mb_r[63:32] : mb_r[31:0];
    pp   = {32'd0, opa} * {32'd0, opb};
    hsel = {1'b0, ph_r[1]} + {1'b0, ph_r[0]};
    sh   = {64'd0, pp} << {hsel, 5'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      ph_r   <= '0;
      acc_r  <= '0;
      neg_r  <= req.a[63] ^ req.b[63];
      ma_r   <= req.a[63] ? -req.a : req.a;
      mb_r   <= req.b[63] ? -req.b : req.b;
    end else if (busy_r) begin
      acc_r <= acc_r + sh;
      ph_r  <= ph_r + 1'b1;
      if (ph_r == 3'd3) busy_r <= 1'b0;
    end
  end

  always_comb begin
    rnd  = (acc_r + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    mag  = rnd[63:0];
    prod = neg_r ? -mag : mag;
  end
  assign busy = busy_r;
endmodule
`default_nettype wire

// ----- hw/rtl/eased_tween_generator_top.sv -----
`default_nettype none
// Eased tween generator. Each input beat is a restart (func 0) or a tick
// (func 1, adds step_time to the elapsed time, saturating); every beat
// returns one result beat with the eased value and a done flag. Progress
// elapsed/duration comes from a bit-serial divider, then a small sequencer
// runs the curve through one shared multiplier (curve products: none for
// linear, 1 for quad, 2 for cubic, 4 for back ease-out), then one more
// product scales the difference. A tick that finds the tween inactive, or
// that ends it, returns the end value through the S_OUT state. in_ready is
// low while a beat is in work and stays low until its result beat is
// taken. Configuration (cfg_index 0 start, 1 end, 2 duration, 3 curve)
// must be written by the user only while idle; the block itself does not
// enforce it. A zero duration means 0.2 s.
module eased_tween_generator_top #(
  parameter int unsigned FRAC_BITS = etg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  input  wire logic [31:0]                   in_step_time,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [31:0]                 out_value,
  output logic                               out_done_res,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [etg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  import etg_pkg::*;

  localparam int unsigned NUM_W = 32 + FRAC_BITS;
  localparam logic [63:0] ONE   = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF  = 64'd1 << (FRAC_BITS - 1);
  localparam logic [63:0] C1    = q30_round(C1_Q30, FRAC_BITS);
  localparam logic [31:0] DDUR  = 32'(q30_round(DEF_DUR_Q30, FRAC_BITS));

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_CURVE = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_SCALE = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r;
  logic [31:0] start_r, end_r, dur_r, elapsed_r;
  logic [1:0]  curve_r;
  logic        running_r;
  logic [2:0]  step_r;     // curve step index
  logic [63:0] t_r, a_r, b_r, e_r;
  logic        div_go_r;
  logic        mul_go_r;
  logic [31:0] eff_dur;
  logic        div_busy, mul_busy;
  logic [NUM_W-1:0] quo;
  logic [63:0] prod;
  mul_req_t    mreq;
  logic [32:0] sum;
  logic [31:0] new_el;
  logic [63:0] r;
  logic [63:0] rs;

  assign eff_dur  = (dur_r != 32'd0) ? dur_r : DDUR;
  assign in_ready = (state_r == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;

  etg_div #(.NUM_W(NUM_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go_r),
    .num({elapsed_r, FRAC_BITS'(0)}), .den(eff_dur),
    .busy(div_busy), .quo(quo)
  );

  assign mreq = '{start: mul_go_r, a: a_r, b: b_r};

  etg_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .req(mreq), .busy(mul_busy), .prod(prod)
  );

  assign sum    = {1'b0, elapsed_r} + {1'b0, in_step_time};
  assign new_el = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  // final value: start + diff*e, saturated
  assign rs = {{32{start_r[31]}}, start_r};
  assign r  = rs + prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      end_r     <= '0;
      dur_r     <= '0;
      curve_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START: start_r <= cfg_data;
        REG_END:   end_r   <= cfg_data;
        REG_DUR:   dur_r   <= cfg_data;
        REG_CURVE: curve_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      elapsed_r <= '0;
      running_r <= 1'b0;
      out_valid <= 1'b0;
      div_go_r  <= 1'b0;
      mul_go_r  <= 1'b0;
      step_r    <= '0;
    end else begin
      div_go_r <= 1'b0;
      mul_go_r <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (!in_func) begin
              elapsed_r <= '0;
              running_r <= 1'b1;
              div_go_r  <= 1'b1;
              state_r   <= S_DIV;
            end else if (running_r) begin
              elapsed_r <= new_el;
              if (new_el >= eff_dur) begin
                running_r <= 1'b0;
                state_r   <= S_OUT;
              end else begin
                div_go_r <= 1'b1;
                state_r  <= S_DIV;
              end
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_DIV: begin
          if (!div_go_r && !div_busy) begin
            t_r     <= (quo > NUM_W'(ONE)) ? ONE : 64'(quo);
            step_r  <= '0;
            state_r <= S_CURVE;
          end
        end
        S_CURVE: begin
          // issue next product or finish curve
          state_r  <= S_MUL;
          mul_go_r <= 1'b1;
          case (curve_t'(curve_r))
            CURVE_LINEAR: begin
              e_r      <= t_r;
              state_r  <= S_SCALE;
              mul_go_r <= 1'b0;
            end
            CURVE_QUAD: begin
              if (step_r == 3'd0) begin
                a_r <= ONE - t_r; b_r <= ONE - t_r;
              end else begin
                e_r <= ONE - e_r; state_r <= S_SCALE; mul_go_r <= 1'b0;
              end
            end
            CURVE_CUBIC: begin
              if (step_r == 3'd0) begin
                a_r <= (t_r < HALF) ? t_r : ONE - t_r;
                b_r <= (t_r < HALF) ? t_r : ONE - t_r;
              end else if (step_r == 3'd1) begin
                a_r <= e_r; b_r <= (t_r < HALF) ? t_r : ONE - t_r;
              end else begin
                e_r <= (t_r < HALF) ? (e_r << 2) : ONE - (e_r << 2);
                state_r <= S_SCALE; mul_go_r <= 1'b0;
              end
            end
            default: begin
              // x=t-1; step0 x2=x*x; step1 x3=x2*x; step2 C3*x3; step3 C1*x2
              if (step_r == 3'd0) begin
                a_r <= t_r - ONE; b_r <= t_r - ONE;
              end else if (step_r == 3'd1) begin
                a_r <= e_r; b_r <= t_r - ONE; t_r <= e_r;  // t_r keeps x2
              end else if (step_r == 3'd2) begin
                a_r <= C1 + ONE; b_r <= e_r;
              end else if (step_r == 3'd3) begin
                a_r <= C1; b_r <= t_r; t_r <= e_r;         // t_r keeps C3 term
              end else begin
                e_r <= ONE + t_r + e_r;
                state_r <= S_SCALE; mul_go_r <= 1'b0;
              end
            end
          endcase
        end
        S_MUL: begin
          if (!mul_go_r && !mul_busy) begin
            e_r     <= prod;
            step_r  <= step_r + 1'b1;
            state_r <= S_CURVE;
          end
        end
        S_SCALE: begin
          a_r      <= {{32{end_r[31]}}, end_r} - {{32{start_r[31]}}, start_r};
          b_r      <= e_r[63] ? 64'd0 : e_r;
          mul_go_r <= 1'b1;
          state_r  <= S_FIN;
        end
        S_FIN: begin
          if (!mul_go_r && !mul_busy) begin
            out_value    <= ($signed(r) > 64'sd2147483647) ? 32'h7FFF_FFFF :
                            ($signed(r) < -64'sd2147483648) ? 32'h8000_0000 : r[31:0];
            out_done_res <= 1'b0;
            out_valid    <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_OUT: begin
          out_value    <= end_r;
          out_done_res <= 1'b1;
          out_valid    <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
